@@ hdl/fct_pkg.sv @@
package fct_pkg;

  // Fixed field widths
  localparam int MODE_W     = 2;
  localparam int NORM_W     = 18;
  localparam int OFF_W      = 48;
  localparam int PIDX_W     = 3;
  localparam int VERD_W     = 2;
  // Radius is Q15.8, distances are scaled by 2^24
  localparam int RAD_SHIFT  = 16;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_POINT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPHERE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOX    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd3;

  // Verdict codes
  localparam logic [VERD_W-1:0] VERD_INSIDE  = 2'd0;
  localparam logic [VERD_W-1:0] VERD_CROSS   = 2'd1;
  localparam logic [VERD_W-1:0] VERD_OUTSIDE = 2'd2;
  localparam logic [VERD_W-1:0] VERD_UNUSED  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic              capture;      // latch query operands, clear flags
    logic              load;         // write one plane
    logic              issue;        // start one plane pass
    logic              phase;        // box: 0 center pass, 1 extent pass
    logic [PIDX_W-1:0] plane;        // plane visited by this pass
    logic              result_load;  // latch verdict into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic box_query;
  } stat_t;

endpackage

@@ hdl/frustum_cull_test.sv @@
// Frustum culling test. Six (NUM_PLANES) planes, each an inward Q1.16 normal
// and an offset scaled by 2^24, are loaded with mode 3 requests (no verdict;
// an index at or past NUM_PLANES is dropped) and are zero after reset.
// Mode 0 tests a point, mode 1 a sphere (center a, radius bx) and mode 2 a
// box (min a, max b); each returns one verdict: 0 inside, 1 intersecting,
// 2 outside. Tests run one at a time through a shared three-lane multiply
// unit followed by an adder stage and a classify stage: a point or sphere
// visits one plane per cycle, and a box makes a center pass and then an
// extent pass per plane. A test request blocks further requests until its
// verdict is latched. The verdict sits in an output register, so the next
// request is taken while it waits to be read; that test then holds its own
// verdict back until the register is read.
module frustum_cull_test import fct_pkg::*; #(
  parameter int NUM_PLANES = 6,
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic        [MODE_W-1:0]     mode,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] bz,
  input  logic        [PIDX_W-1:0]     plane_index,
  input  logic signed [NORM_W-1:0]     normal_x,
  input  logic signed [NORM_W-1:0]     normal_y,
  input  logic signed [NORM_W-1:0]     normal_z,
  input  logic signed [OFF_W-1:0]      plane_offset,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [VERD_W-1:0]     verdict
);

  cmd_t  cmd;
  stat_t st;

  fct_ctrl #(
    .NUM_PLANES(NUM_PLANES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  fct_datapath #(
    .NUM_PLANES(NUM_PLANES),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .mode         (mode),
    .ax           (ax),
    .ay           (ay),
    .az           (az),
    .bx           (bx),
    .by           (by),
    .bz           (bz),
    .plane_index  (plane_index),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .plane_offset (plane_offset),
    .verdict      (verdict)
  );

  // A test request blocks further requests until it finishes
  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode != MODE_LOAD) |=> !in_ready)
    else $error("request taken while a test is in progress");

  // A plane load never produces a verdict
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode == MODE_LOAD && !out_valid) |=> !out_valid)
    else $error("plane load produced a verdict");

  // Verdict only appears once the pipeline has drained
  a_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> !st.pipe_busy)
    else $error("verdict latched with passes still in flight");

  // No pass is issued while idle
  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !in_ready)
    else $error("plane pass issued while accepting requests");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict != VERD_UNUSED)
    else $error("invalid verdict code");

endmodule

@@ hdl/fct_ctrl.sv @@
module fct_ctrl import fct_pkg::*; #(
  parameter int NUM_PLANES = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] mode,
  output logic              out_valid,
  input  logic              out_ready,
  input  stat_t             st,
  output cmd_t              cmd
);

  localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             phase, phase_next;
  logic             out_valid_next;
  logic             accept;
  logic             last_plane;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    phase_next      = phase;
    cmd             = '0;
    cmd.phase       = phase;
    cmd.plane       = PIDX_W'(cnt);
    in_ready        = (state == ST_IDLE);
    accept          = in_valid && in_ready;
    last_plane      = (cnt == IDX_W'(NUM_PLANES - 1));
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            cnt_next    = '0;
            phase_next  = 1'b0;
            state_next  = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        // box takes a center pass and an extent pass per plane
        if (st.box_query && !phase) begin
          phase_next = 1'b1;
        end else begin
          phase_next = 1'b0;
          cnt_next   = cnt + 1'b1;
          if (last_plane) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!st.pipe_busy && (!out_valid || out_ready)) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    if (cmd.result_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

@@ hdl/fct_datapath.sv @@
module fct_datapath import fct_pkg::*; #(
  parameter int NUM_PLANES = 6,
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output stat_t                        st,
  input  logic        [MODE_W-1:0]     mode,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] bz,
  input  logic        [PIDX_W-1:0]     plane_index,
  input  logic signed [NORM_W-1:0]     normal_x,
  input  logic signed [NORM_W-1:0]     normal_y,
  input  logic signed [NORM_W-1:0]     normal_z,
  input  logic signed [OFF_W-1:0]      plane_offset,
  output logic        [VERD_W-1:0]     verdict
);

  localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int OPW   = COORD_BITS + 1;          // sum or difference of two coords
  localparam int NCW   = NORM_W + 1;              // normal or its magnitude
  localparam int PW    = OPW + NCW;               // one product
  localparam int OFW   = OFF_W + 1;               // offset or doubled offset
  localparam int ACC_W = ((PW > OFW) ? PW : OFW) + 3;
  localparam int SW    = ACC_W + 1;

  function automatic logic signed [NCW-1:0] mag(input logic signed [NORM_W-1:0] n);
    logic signed [NCW-1:0] w;
    w = NCW'(n);
    mag = n[NORM_W-1] ? -w : w;
  endfunction

  // Plane store
  logic signed [NORM_W-1:0] nx_r [NUM_PLANES];
  logic signed [NORM_W-1:0] ny_r [NUM_PLANES];
  logic signed [NORM_W-1:0] nz_r [NUM_PLANES];
  logic signed [OFF_W-1:0]  off_r [NUM_PLANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        nx_r[i]  <= '0;
        ny_r[i]  <= '0;
        nz_r[i]  <= '0;
        off_r[i] <= '0;
      end
    end else if (cmd.load && (int'(plane_index) < NUM_PLANES)) begin
      nx_r[plane_index[IDX_W-1:0]]  <= normal_x;
      ny_r[plane_index[IDX_W-1:0]]  <= normal_y;
      nz_r[plane_index[IDX_W-1:0]]  <= normal_z;
      off_r[plane_index[IDX_W-1:0]] <= plane_offset;
    end
  end

  // Query operands: box keeps doubled center and doubled extent
  logic        [MODE_W-1:0]     mode_r;
  logic signed [OPW-1:0]        sum_x, sum_y, sum_z;
  logic signed [OPW-1:0]        dif_x, dif_y, dif_z;
  logic signed [COORD_BITS-1:0] rad;
  logic                         is_box_in;

  assign is_box_in = (mode == MODE_BOX);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode;
      sum_x  <= is_box_in ? OPW'(ax) + OPW'(bx) : OPW'(ax);
      sum_y  <= is_box_in ? OPW'(ay) + OPW'(by) : OPW'(ay);
      sum_z  <= is_box_in ? OPW'(az) + OPW'(bz) : OPW'(az);
      dif_x  <= OPW'(bx) - OPW'(ax);
      dif_y  <= OPW'(by) - OPW'(ay);
      dif_z  <= OPW'(bz) - OPW'(az);
      rad    <= bx;
    end
  end

  // Operand select for the three multiplier lanes
  logic [IDX_W-1:0]      sel;
  logic signed [OPW-1:0] op_x, op_y, op_z;
  logic signed [NCW-1:0] cf_x, cf_y, cf_z;
  logic signed [OFW-1:0] off_sel;
  logic signed [OFW-1:0] off_ext;

  always_comb begin
    sel     = cmd.plane[IDX_W-1:0];
    op_x    = cmd.phase ? dif_x : sum_x;
    op_y    = cmd.phase ? dif_y : sum_y;
    op_z    = cmd.phase ? dif_z : sum_z;
    cf_x    = cmd.phase ? mag(nx_r[sel]) : NCW'(nx_r[sel]);
    cf_y    = cmd.phase ? mag(ny_r[sel]) : NCW'(ny_r[sel]);
    cf_z    = cmd.phase ? mag(nz_r[sel]) : NCW'(nz_r[sel]);
    off_ext = OFW'(off_r[sel]);
    if (cmd.phase) begin
      off_sel = '0;
    end else if (mode_r == MODE_BOX) begin
      off_sel = off_ext <<< 1;
    end else begin
      off_sel = off_ext;
    end
  end

  // Stage 1: products
  logic signed [PW-1:0]  p_x, p_y, p_z;
  logic signed [OFW-1:0] off1;
  logic                  v1, ph1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
    end
    p_x  <= PW'(op_x) * PW'(cf_x);
    p_y  <= PW'(op_y) * PW'(cf_y);
    p_z  <= PW'(op_z) * PW'(cf_z);
    off1 <= off_sel;
    ph1  <= cmd.phase;
  end

  // Stage 2: sum of lanes and offset
  logic signed [ACC_W-1:0] acc;
  logic                    v2, ph2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    acc <= ACC_W'(p_x) + ACC_W'(p_y) + ACC_W'(p_z) + ACC_W'(off1);
    ph2 <= ph1;
  end

  // Stage 3: classify against this plane
  logic signed [ACC_W-1:0] r_big, neg_r, s_hold;
  logic signed [SW-1:0]    s_plus, s_minus;
  logic                    any_out, any_mid;

  always_comb begin
    r_big   = ACC_W'(rad) <<< RAD_SHIFT;
    neg_r   = -r_big;
    s_plus  = SW'(s_hold) + SW'(acc);
    s_minus = SW'(s_hold) - SW'(acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_out <= 1'b0;
      any_mid <= 1'b0;
    end else if (cmd.capture) begin
      any_out <= 1'b0;
      any_mid <= 1'b0;
    end else if (v2) begin
      case (mode_r)
        MODE_POINT: begin
          if (acc < 0) any_out <= 1'b1;
        end
        MODE_SPHERE: begin
          if (acc < neg_r) any_out <= 1'b1;
          else if (acc < r_big) any_mid <= 1'b1;
        end
        MODE_BOX: begin
          if (ph2) begin
            if (s_plus < 0) any_out <= 1'b1;
            else if (s_minus <= 0) any_mid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Center pass result waits for the extent pass
  always_ff @(posedge clk) begin
    if (v2 && !ph2) begin
      s_hold <= acc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      verdict <= any_out ? VERD_OUTSIDE : (any_mid ? VERD_CROSS : VERD_INSIDE);
    end
  end

  assign st.pipe_busy = v1 | v2;
  assign st.box_query = (mode_r == MODE_BOX);

endmodule
